FILE: sv/rrq_pkg.sv
package rrq_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W  = 8;
    localparam int OCC_W = 4;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(SLOTS);

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_FLUSH  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             accepted;
        logic [ID_W-1:0]  popped_id;
        logic             found;
        logic [OCC_W-1:0] occupancy;
    } t_result;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    // entries between read and write index, wrapping at SLOTS
    function automatic logic [IDX_W-1:0] queued(input logic [IDX_W-1:0] w,
                                                input logic [IDX_W-1:0] r);
        logic [IDX_W:0] s;
        if (w >= r) begin
            s = {1'b0, w} - {1'b0, r};
        end else begin
            s = {1'b0, w} + SLOTS_EXT - {1'b0, r};
        end
        return s[IDX_W-1:0];
    endfunction

    // occupancy field is 4 bits: count modulo 16
    function automatic logic [OCC_W-1:0] occ_field(input logic [IDX_W-1:0] cnt);
        logic [IDX_W+OCC_W-1:0] t;
        t = {{OCC_W{1'b0}}, cnt};
        return t[OCC_W-1:0];
    endfunction

endpackage

FILE: sv/rrq_mem.sv
module rrq_mem
    import rrq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [ID_W-1:0]  i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [ID_W-1:0]  o_rdata
);

    logic [ID_W-1:0] r_mem [SLOTS];
    logic [ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rrq_ctrl.sv
module rrq_ctrl
    import rrq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_action         i_action,
    input  logic [ID_W-1:0] i_item_id,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output t_result         o_res
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [IDX_W-1:0] r_left, n_left;
    logic [ID_W-1:0]  r_id, n_id;
    logic             r_acc, n_acc;
    logic [ID_W-1:0]  r_pop, n_pop;
    logic             r_found, n_found;

    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [ID_W-1:0]  mem_rdata;
    logic [IDX_W-1:0] cnt;
    logic             is_empty, is_full, in_acc;

    rrq_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_idx),
        .i_wdata (i_item_id),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign cnt      = queued(r_wr_idx, r_rd_idx);
    assign is_empty = (r_wr_idx == r_rd_idx);
    assign is_full  = (next_slot(r_wr_idx) == r_rd_idx);
    assign in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_left  <= n_left;
        r_id    <= n_id;
        r_acc   <= n_acc;
        r_pop   <= n_pop;
        r_found <= n_found;
    end

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_id        = r_id;
        n_acc       = r_acc;
        n_pop       = r_pop;
        n_found     = r_found;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = r_rd_idx;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_id    = i_item_id;
                    n_acc   = 1'b0;
                    n_pop   = '0;
                    n_found = 1'b0;
                    n_state = ST_EMIT;
                    unique case (i_action)
                        ACT_PUSH: begin
                            if (!is_full) begin
                                mem_we   = 1'b1;
                                n_wr_idx = next_slot(r_wr_idx);
                                n_acc    = 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (!is_empty) begin
                                mem_re   = 1'b1;
                                n_rd_idx = next_slot(r_rd_idx);
                                n_acc    = 1'b1;
                                n_state  = ST_POP;
                            end
                        end
                        ACT_LOOKUP: begin
                            if (!is_empty) begin
                                mem_re  = 1'b1;
                                n_ptr   = next_slot(r_rd_idx);
                                n_left  = cnt - 1'b1;
                                n_state = ST_SCAN;
                            end
                        end
                        ACT_FLUSH: begin
                            n_wr_idx = '0;
                            n_rd_idx = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_POP: begin
                n_pop   = mem_rdata;
                n_state = ST_EMIT;
            end
            ST_SCAN: begin
                // data of the previous read is here; compare, else fetch next
                mem_raddr = r_ptr;
                if (mem_rdata == r_id) begin
                    n_found = 1'b1;
                    n_state = ST_EMIT;
                end else if (r_left == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    mem_re  = 1'b1;
                    n_ptr   = next_slot(r_ptr);
                    n_left  = r_left - 1'b1;
                end
            end
            ST_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_res.accepted  = r_acc;
    assign o_res.popped_id = r_pop;
    assign o_res.found     = r_found;
    assign o_res.occupancy = occ_field(cnt);

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !mem_we)
        else $error("store written during lookup scan");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_idx <= LAST_SLOT) && (r_rd_idx <= LAST_SLOT))
        else $error("queue index beyond last slot");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_action == ACT_FLUSH) |=> (r_wr_idx == '0) && (r_rd_idx == '0))
        else $error("flush did not empty the queue");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> o_res_valid && $stable(o_res))
        else $error("pending result changed before handoff");

endmodule

FILE: sv/rrq_out.sv
module rrq_out
    import rrq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    output logic        o_res_ready,
    input  t_result     i_res,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_data
);

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {2'b00, r_res.occupancy, r_res.found, r_res.popped_id, r_res.accepted};

endmodule

FILE: sv/ring_request_queue_with_lookup.sv
// Channel   Dir  Signals                 Contents
// s_axis    in   tvalid tready tdata     tdata[7:0] item_id
//                tuser                   tuser[1:0] action
// m_axis    out  tvalid tready tdata     tdata[0] accepted, [8:1] popped_id,
//                                        [9] found, [13:10] occupancy
//
// One item at a time. Push and flush go from idle straight to the emit state;
// pop passes through a pop state for the registered slot store read. Lookup
// compares k entries, k those compared before a match or the end, so up to
// SLOTS-1; the single read port of the slot store paces it, one entry a cycle.
// Reset (synchronous, active low) empties the queue; the slot store is not cleared.
// A stalled m_axis holds the result in the output register; one further item
// may be taken and worked on meanwhile, its result waits until that register frees.
module ring_request_queue_with_lookup
    import rrq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] item_id
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] accepted, [8:1] popped_id, [9] found,
                                        // [13:10] occupancy, [15:14] zero
);

    t_result res;
    logic    res_valid;
    logic    res_ready;

    // control, indices and slot store
    rrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (t_action'(s_axis_tuser)),
        .i_item_id   (s_axis_tdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register decouples the result from the master side
    rrq_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata)
    );

endmodule
